/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL that carries checks.
// All checks use clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/twa_pkg.sv */
`timescale 1ns / 1ps

package twa_pkg;

  // Store geometry
  localparam int Bins     = 1024;
  localparam int Channels = 4;
  localparam int BIN_W    = 10;
  localparam int CH_W     = 2;
  localparam int ADDR_W   = CH_W + BIN_W;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 16;
  localparam int VAL_W    = 16;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = 5;

  // Operation codes
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_EOW   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRE_TRIGGER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_POSITION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_IN_USE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch input word fields
    logic acc_rd;     // read bin for accumulate
    logic acc_wr;     // write saturated sum back
    logic clr_start;  // zero the count and rewind the clear pointer
    logic clr_wr;     // write one zero entry
    logic cnt_inc;    // end of waveform
    logic rd_mem;     // read bin for average
    logic div_load;   // start the divider
    logic div_step;   // one quotient bit
    logic out_load;   // move result into the output register
  } twa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic acc_ok;
    logic clr_last;
    logic div_last;
    logic out_free;
  } twa_status_t;

endpackage

/* hdl/twa_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module twa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/twa_datapath.sv */
`timescale 1ns / 1ps

module twa_datapath
  import twa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input word fields
  input  logic [CH_W-1:0]      ch_i,
  input  logic [BIN_W-1:0]     idx_i,
  input  logic [BIN_W-1:0]     trig_i,
  input  logic [VAL_W-1:0]     val_i,
  // control
  input  twa_cmd_t             cmd_i,
  output twa_status_t          status_o,
  // result
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [CH_W-1:0]      out_ch_o,
  output logic [BIN_W-1:0]     out_bin_o,
  output logic [VAL_W-1:0]     out_avg_o,
  output logic [CNT_W-1:0]     out_cnt_o
);

  // Configuration registers
  logic [BIN_W-1:0] pre_q, align_q;
  logic [CFG_W-1:0] siu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= BIN_W'(20);
      align_q <= BIN_W'(100);
      siu_q   <= CFG_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PRE_TRIGGER:    pre_q   <= cfg_data_i[BIN_W-1:0];
        REG_ALIGN_POSITION: align_q <= cfg_data_i[BIN_W-1:0];
        REG_SAMPLES_IN_USE: siu_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured word
  logic [CH_W-1:0]  ch_q;
  logic [BIN_W-1:0] idx_q, trig_q;
  logic [VAL_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q   <= ch_i;
      idx_q  <= idx_i;
      trig_q <= trig_i;
      val_q  <= val_i;
    end
  end

  // Window test and target bin
  logic [BIN_W:0]   idx_pre, idx_inc, idx_align;
  logic [BIN_W+1:0] bin_diff;
  logic             win_ok, bin_ok, ch_ok;

  always_comb begin
    idx_pre   = {1'b0, idx_q} + {1'b0, pre_q};
    idx_inc   = {1'b0, idx_q} + (BIN_W+1)'(1);
    idx_align = {1'b0, idx_q} + {1'b0, align_q};
    bin_diff  = {1'b0, idx_align} - {2'b00, trig_q};
    win_ok    = (idx_pre >= {1'b0, trig_q}) && (idx_inc < siu_q);
    bin_ok    = !bin_diff[BIN_W+1] && !bin_diff[BIN_W];
    ch_ok     = 32'(ch_q) < Channels;
  end

  assign status_o.acc_ok = win_ok && bin_ok && ch_ok;

  // Clear pointer and waveform count
  logic [ADDR_W-1:0] clr_q;
  logic [CNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + ADDR_W'(1);
      if (cmd_i.cnt_inc && cnt_q != '1) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign status_o.clr_last = &clr_q;

  // Sum store
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SUM_W-1:0]  wdata, rdata;
  logic              we, re;
  logic [SUM_W:0]    acc_sum;

  always_comb begin
    acc_sum = {rdata[SUM_W-1], rdata} + (SUM_W+1)'(signed'(val_q));
    wdata   = '0;
    if (cmd_i.acc_wr) begin
      if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
        wdata = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        wdata = acc_sum[SUM_W-1:0];
      end
    end
    we    = cmd_i.acc_wr || cmd_i.clr_wr;
    waddr = cmd_i.clr_wr ? clr_q : {ch_q, bin_diff[BIN_W-1:0]};
    re    = cmd_i.acc_rd || cmd_i.rd_mem;
    raddr = cmd_i.acc_rd ? {ch_q, bin_diff[BIN_W-1:0]} : {ch_q, idx_q};
  end

  twa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (Bins * Channels)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Restoring divider, one quotient bit per step, on the magnitude of the sum
  logic [CNT_W-1:0]    rem_q;
  logic [SUM_W-1:0]    quo_q;
  logic [CNT_W-1:0]    dvs_q;
  logic                neg_q, zero_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [CNT_W:0]      trial;
  logic                ge;

  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_load) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
    end
  end

  // remainder stays below the divisor, so it fits the count width
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= '0;
      quo_q  <= rdata[SUM_W-1] ? (~rdata + SUM_W'(1)) : rdata;
      neg_q  <= rdata[SUM_W-1];
      dvs_q  <= cnt_q;
      zero_q <= (cnt_q == '0) || !ch_ok;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign status_o.div_last = &dcnt_q;

  // Sign and clamp of the quotient
  logic [VAL_W-1:0] avg;

  always_comb begin
    if (zero_q) begin
      avg = '0;
    end else if (neg_q) begin
      avg = (quo_q > SUM_W'(32768)) ? 16'h8000 : (~quo_q[VAL_W-1:0] + VAL_W'(1));
    end else begin
      avg = (quo_q > SUM_W'(32767)) ? 16'h7fff : quo_q[VAL_W-1:0];
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ch_o  <= ch_q;
      out_bin_o <= idx_q;
      out_avg_o <= avg;
      out_cnt_o <= dvs_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* hdl/twa_ctrl.sv */
`timescale 1ns / 1ps

module twa_ctrl
  import twa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  twa_status_t status_i,
  output twa_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLR     = 3'd1;
  localparam logic [2:0] S_ACC_RD  = 3'd2;
  localparam logic [2:0] S_ACC_WR  = 3'd3;
  localparam logic [2:0] S_RD_MEM  = 3'd4;
  localparam logic [2:0] S_RD_LOAD = 3'd5;
  localparam logic [2:0] S_RD_DIV  = 3'd6;
  localparam logic [2:0] S_RD_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          case (op_i)
            OP_ACC:   state_d = S_ACC_RD;
            OP_EOW:   cmd_o.cnt_inc = 1'b1;
            OP_READ:  state_d = S_RD_MEM;
            OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_ACC_RD: begin
        if (status_i.acc_ok) begin
          cmd_o.acc_rd = 1'b1;
          state_d = S_ACC_WR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ACC_WR: begin
        cmd_o.acc_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_RD_MEM: begin
        cmd_o.rd_mem = 1'b1;
        state_d = S_RD_LOAD;
      end
      S_RD_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d = S_RD_DIV;
      end
      S_RD_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reset starts with a clearing pass over the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/trigger_aligned_waveform_averager.sv */
`timescale 1ns / 1ps

// Four-channel trigger-aligned waveform averager.
// Input stream (s_axis): one word per operation; tuser carries the operation
// (accumulate, end of waveform, read, clear), tdata the channel, sample index,
// trigger time and signed sample. Output stream (m_axis): one word per read
// with channel, bin, average and waveform count.
// Configuration: cfg_we_i writes pre_trigger (0), align_position (1) or
// samples_in_use (2) from cfg_data_i; write only while the block is idle.
// Operations: accumulate is a read-modify-write of one RAM entry, with no
// write when the sample falls outside the window or the store; end of
// waveform is counted as it is accepted; read fetches the sum, runs the
// 32-step bit-serial divider, and takes no new word until the result is
// loaded; clear zeroes the store, one RAM entry per cycle.
// Reset: the same clearing pass runs after rst_ni is released; s_axis_tready
// stays low until it is done. Configuration resets to 20, 100, 1000.
// Stall: the result sits in an output register; further words are still
// accepted while it waits. A following read is taken and divided, then holds
// s_axis_tready low until the register is free.
module trigger_aligned_waveform_averager
  import twa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,  // channel, sample_index, trigger_time,
                                              // sample_value, zero pad
  input  logic [1:0]           s_axis_tuser,  // operation
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata   // read_channel, read_bin, average,
                                              // waveform_count, zero pad
);

`include "assert_macros.svh"

  twa_cmd_t    cmd;
  twa_status_t status;

  logic [CH_W-1:0]  out_ch;
  logic [BIN_W-1:0] out_bin;
  logic [VAL_W-1:0] out_avg;
  logic [CNT_W-1:0] out_cnt;

  twa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  twa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ch_i        (s_axis_tdata[1:0]),
    .idx_i       (s_axis_tdata[11:2]),
    .trig_i      (s_axis_tdata[21:12]),
    .val_i       (s_axis_tdata[37:22]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ch_o    (out_ch),
    .out_bin_o   (out_bin),
    .out_avg_o   (out_avg),
    .out_cnt_o   (out_cnt)
  );

  assign m_axis_tdata = {4'b0000, out_cnt, out_avg, out_bin, out_ch};

  // A result is only loaded into a free output slot
  `ASSERT_IMPL(a_out_load_free, cmd.out_load, status.out_free, "output overwritten")
  // No store write while a new word may be taken
  `ASSERT_IMPL(a_no_wr_idle, s_axis_tready, !cmd.acc_wr && !cmd.clr_wr, "write while idle")
  // Accumulate write always follows its read
  `ASSERT_NEXT(a_acc_rmw, cmd.acc_rd, cmd.acc_wr, "accumulate write missing")
  // Divider steps never run alongside a store access
  `ASSERT_IMPL(a_div_quiet, cmd.div_step, !cmd.acc_rd && !cmd.rd_mem && !cmd.clr_wr, "divider overlaps store access")

endmodule
